// ===== hw/rtl/fdt_pkg.sv =====
// Shared types, constants and tables for the fixed-point to decimal text block.
`timescale 1ns / 1ps

package fdt_pkg;

    localparam int INT_W       = 31;
    localparam int FRAC_BITS   = 20;
    localparam int FD_W        = 3;
    localparam int CHAR_W      = 7;

    localparam int STORE_DEPTH = 16;
    localparam int STORE_AW    = 4;
    localparam int DIGIT_W     = 4;
    localparam int CNT_W       = 5;

    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = 1;
    localparam int Q_CW        = 2;

    localparam int VAL_W       = 32;
    localparam int PROD_W      = 64;
    localparam int POW_W       = 24;

    // floor(v / 10) == (v * RECIP) >> RECIP_SHIFT for every 32-bit v
    localparam logic [VAL_W-1:0] RECIP       = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam int               TEN         = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 7'h2E;

    typedef struct packed {
        logic [INT_W-1:0]     integer_part;
        logic [FRAC_BITS-1:0] fraction_part;
    } fdt_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } fdt_out_t;

    // One classified number waiting for the back end
    typedef struct packed {
        logic [INT_W-1:0]     ipart;
        logic [FRAC_BITS-1:0] fpart;
        logic [FD_W-1:0]      fd;
        logic                 has_frac;
    } fdt_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } fdt_qstat_t;

    function automatic logic [POW_W-1:0] pow10(input logic [FD_W-1:0] n);
        logic [POW_W-1:0] p;
        case (n)
            3'd0: p = 24'd1;
            3'd1: p = 24'd10;
            3'd2: p = 24'd100;
            3'd3: p = 24'd1000;
            3'd4: p = 24'd10000;
            3'd5: p = 24'd100000;
            3'd6: p = 24'd1000000;
            3'd7: p = 24'd10000000;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/fixed_point_to_decimal_text.sv =====
// Top level of the fixed-point to decimal ASCII text converter.
//
//  channel   | handshake             | payload                         | transaction
//  ----------+-----------------------+---------------------------------+------------------
//  item      | item_valid/item_stall | fdt_in_t  (integer, Q0.20 frac) | one number in
//  char      | char_valid/char_stall | fdt_out_t (ASCII char, last)    | one character out
//  cfg       | cfg_valid/cfg_ready   | cfg_data  (fraction digits)     | register write
//
// Steps: each digit takes a reciprocal multiply step (S_MUL) and a quotient and remainder
//   step (S_DIV) in the shared divide-by-ten unit, which writes it to the digit store; the
//   stored digits are then emitted most significant first from S_EMIT. With fractions, the
//   point is sent from S_DOT before the fraction digits are extracted the same way.
// The two-entry queue takes new numbers while the back end is busy.
// Reset: asynchronous, clears control state; fraction digits reset to 2.
// A stalled char transaction holds the sequencer in S_EMIT or S_DOT; nothing is dropped.

`timescale 1ns / 1ps

module fixed_point_to_decimal_text
    import fdt_pkg::*;
#(
    parameter int INT_DIGITS      = 10,
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic            clk,
    input  logic            rst_n,

    input  logic            item_valid,
    output logic            item_stall,
    input  fdt_in_t         item_data,

    output logic            char_valid,
    input  logic            char_stall,
    output fdt_out_t        char_data,

    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [FD_W-1:0] cfg_data
);

    fdt_entry_t entry;
    fdt_entry_t head;
    fdt_qstat_t qstat;
    logic       pop;

    // front: config register and classification of the incoming number
    fdt_front #(
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .item_data (item_data),
        .entry     (entry)
    );

    // decouples acceptance from the digit sequencer
    fdt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (item_valid),
        .wr_entry (entry),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    assign item_stall = qstat.full;

    // back: digit extraction, digit store and character output register
    fdt_back #(
        .INT_DIGITS (INT_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule

// ===== hw/rtl/fdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fdt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/fdt_queue.sv =====
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module fdt_queue
    import fdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    input  fdt_entry_t wr_entry,
    input  logic       pop,
    output fdt_entry_t head,
    output fdt_qstat_t qstat
);

    fdt_entry_t        entries_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign qstat.full      = (count_reg == Q_CW'(Q_DEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign do_push         = wr_valid && !qstat.full;
    assign do_pop          = pop && qstat.not_empty;
    assign head            = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== hw/rtl/fdt_front.sv =====
// Front end: fraction digit register, digit count clamp and item classification.
`timescale 1ns / 1ps

module fdt_front
    import fdt_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [FD_W-1:0] cfg_data,
    input  fdt_in_t         item_data,
    output fdt_entry_t      entry
);

    logic [FD_W-1:0] fraction_digits_reg;
    logic [FD_W-1:0] fd_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_digits_reg <= FD_W'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            fraction_digits_reg <= cfg_data;
        end
    end

    // clamp to the widest fraction this build prints
    assign fd_sat = (int'(fraction_digits_reg) > MAX_FRAC_DIGITS) ?
                    FD_W'(MAX_FRAC_DIGITS) : fraction_digits_reg;

    assign entry.ipart    = item_data.integer_part;
    assign entry.fpart    = item_data.fraction_part;
    assign entry.fd       = fd_sat;
    assign entry.has_frac = (fd_sat != '0);

endmodule

// ===== hw/rtl/fdt_back.sv =====
// Back end: digit extraction by reciprocal multiply, digit store and character output.
`timescale 1ns / 1ps

module fdt_back
    import fdt_pkg::*;
#(
    parameter int INT_DIGITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  fdt_entry_t head,
    input  fdt_qstat_t qstat,
    output logic       pop,
    output logic       char_valid,
    input  logic       char_stall,
    output fdt_out_t   char_data
);

    localparam int INT_LIMIT = (INT_DIGITS < STORE_DEPTH) ? INT_DIGITS : STORE_DEPTH;
    localparam int Q_W       = PROD_W - RECIP_SHIFT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_PREP,
        S_EMIT,
        S_FMUL,
        S_DOT
    } state_t;

    state_t                state_reg, state_next;
    logic [VAL_W-1:0]      v_reg, v_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [FRAC_BITS-1:0]  fpart_reg, fpart_next;
    logic [FD_W-1:0]       fd_reg, fd_next;
    logic                  has_frac_reg, has_frac_next;
    logic                  frac_phase_reg, frac_phase_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [CNT_W-1:0]      nz_reg, nz_next;
    logic [CNT_W-1:0]      digit_count_reg, digit_count_next;
    logic [STORE_AW-1:0]   idx_reg, idx_next;
    logic                  char_valid_reg, char_valid_next;
    fdt_out_t              char_data_reg, char_data_next;

    logic [Q_W-1:0]        q;
    logic [VAL_W-1:0]      q_ext;
    logic [VAL_W-1:0]      rem_full;
    logic [DIGIT_W-1:0]    digit;
    logic [CNT_W-1:0]      k_inc;
    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      min_digits;
    logic [CNT_W-1:0]      nz_final;
    logic                  more;
    logic                  slot_free;
    logic                  we;
    logic [DIGIT_W-1:0]    rdata;

    fdt_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (k_reg[STORE_AW-1:0]),
        .wdata (digit),
        .raddr (idx_next),
        .rdata (rdata)
    );

    // quotient and remainder of v_reg by ten, from the registered product
    assign q        = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign q_ext    = VAL_W'(q);
    assign rem_full = v_reg - q_ext * VAL_W'(TEN);
    assign digit    = rem_full[DIGIT_W-1:0];

    assign k_inc      = k_reg + 1'b1;
    assign limit      = frac_phase_reg ? CNT_W'(fd_reg) : CNT_W'(INT_LIMIT);
    assign min_digits = frac_phase_reg ? CNT_W'(fd_reg) : CNT_W'(1);
    assign more       = (k_inc < limit) && ((q_ext != '0) || (k_inc < min_digits));
    assign nz_final   = (digit != '0) ? k_inc : nz_reg;
    assign slot_free  = !char_valid_reg || !char_stall;

    always_comb
    begin
        state_next       = state_reg;
        v_next           = v_reg;
        prod_next        = prod_reg;
        fpart_next       = fpart_reg;
        fd_next          = fd_reg;
        has_frac_next    = has_frac_reg;
        frac_phase_next  = frac_phase_reg;
        k_next           = k_reg;
        nz_next          = nz_reg;
        digit_count_next = digit_count_reg;
        idx_next         = idx_reg;
        char_valid_next  = char_valid_reg && char_stall;
        char_data_next   = char_data_reg;
        pop              = 1'b0;
        we               = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (qstat.not_empty)
                begin
                    pop             = 1'b1;
                    v_next          = VAL_W'(head.ipart);
                    fpart_next      = head.fpart;
                    fd_next         = head.fd;
                    has_frac_next   = head.has_frac;
                    frac_phase_next = 1'b0;
                    k_next          = '0;
                    nz_next         = '0;
                    state_next      = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(v_reg) * PROD_W'(RECIP);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                we     = 1'b1;
                v_next = q_ext;
                k_next = k_inc;
                if (digit != '0)
                begin
                    nz_next = k_inc;
                end
                if (more)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    if (frac_phase_reg)
                    begin
                        digit_count_next = k_inc;
                    end
                    else
                    begin
                        // drop leading zeros, keep at least one digit
                        digit_count_next = (nz_final == '0) ? CNT_W'(1) : nz_final;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                idx_next   = STORE_AW'(digit_count_reg - 1'b1);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    char_valid_next          = 1'b1;
                    char_data_next.character = CHAR_ZERO + CHAR_W'(rdata);
                    char_data_next.last      = (idx_reg == '0) &&
                                               (frac_phase_reg || !has_frac_reg);
                    if (idx_reg == '0)
                    begin
                        state_next = (!frac_phase_reg && has_frac_reg) ? S_FMUL : S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            S_FMUL:
            begin
                prod_next  = PROD_W'(fpart_reg) * PROD_W'(pow10(fd_reg));
                state_next = S_DOT;
            end
            S_DOT:
            begin
                if (slot_free)
                begin
                    char_valid_next          = 1'b1;
                    char_data_next.character = CHAR_DOT;
                    char_data_next.last      = 1'b0;
                    v_next                   = VAL_W'(prod_reg >> FRAC_BITS);
                    frac_phase_next          = 1'b1;
                    k_next                   = '0;
                    nz_next                  = '0;
                    state_next               = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            char_valid_reg  <= 1'b0;
            digit_count_reg <= '0;
            frac_phase_reg  <= 1'b0;
            has_frac_reg    <= 1'b0;
            k_reg           <= '0;
            nz_reg          <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            char_valid_reg  <= char_valid_next;
            digit_count_reg <= digit_count_next;
            frac_phase_reg  <= frac_phase_next;
            has_frac_reg    <= has_frac_next;
            k_reg           <= k_next;
            nz_reg          <= nz_next;
            idx_reg         <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        prod_reg      <= prod_next;
        fpart_reg     <= fpart_next;
        fd_reg        <= fd_next;
        char_data_reg <= char_data_next;
    end

    assign char_valid = char_valid_reg;
    assign char_data  = char_data_reg;

endmodule

// ===== hw/rtl/fdt_checker.sv =====
// Port-level assertions for the decimal text converter, bound to the top level.
`timescale 1ns / 1ps

module fdt_checker
    import fdt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     char_valid,
    input logic     char_stall,
    input fdt_out_t char_data
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid)
        else $error("char_valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> $stable(char_data))
        else $error("char_data changed while stalled");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> ((char_data.character >= CHAR_ZERO) &&
                        (char_data.character <= CHAR_NINE)) ||
                       (char_data.character == CHAR_DOT))
        else $error("character is neither a digit nor a point");

    a_dot_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && (char_data.character == CHAR_DOT) |-> !char_data.last)
        else $error("point marked as last character");

    a_number_starts_digit: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_stall && char_data.last |=>
            !(char_valid && (char_data.character == CHAR_DOT)))
        else $error("number starts with a point");

endmodule

bind fixed_point_to_decimal_text fdt_checker u_fdt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
);
